// ===== design/hysteresis_edge_threshold_top_macros.svh =====
// Assertion helpers shared by the design modules.
`ifndef HYSTERESIS_EDGE_THRESHOLD_TOP_MACROS_SVH
`define HYSTERESIS_EDGE_THRESHOLD_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HET_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define HET_CHECK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/het_pkg.sv =====
package het_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT) + 1;
   localparam int CFG_DIM_W   = 11;
   localparam int PIXEL_W     = 8;
   localparam int EDGE_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [PIXEL_W-1:0]   LOW_RESET    = 8'd50;
   localparam logic [PIXEL_W-1:0]   HIGH_RESET   = 8'd100;
   localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [EDGE_W-1:0]    EDGE_ON      = 8'd255;
   localparam logic [EDGE_W-1:0]    EDGE_OFF     = 8'd0;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      CLS_NONE   = 2'd0,
      CLS_WEAK   = 2'd1,
      CLS_STRONG = 2'd2
   } class_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LOW    = 2'd0,
      REG_HIGH   = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } csr_index_type;

   // Line store word at one column: the two most recent rows.
   typedef struct packed {
      class_type older;
      class_type newer;
   } line_word_type;

   localparam int LINE_WORD_W = $bits(line_word_type);

   typedef struct packed {
      class_type top;
      class_type mid;
      class_type bot;
   } column_type;

   typedef struct packed {
      logic                 emit;
      logic                 last;
      class_type            cls;
      logic [COL_W-1:0]     col;
      logic                 mask_top;
      logic                 mask_bot;
      logic                 mask_left;
      logic                 mask_right;
   } op_type;

endpackage

// ===== design/het_ram.sv =====
module het_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/het_front.sv =====
`include "hysteresis_edge_threshold_top_macros.svh"

module het_front import het_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,
   input  logic                   req_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_DIM_W-1:0]   csr_data,
   input  logic                   q_full,
   output logic                   q_push,
   output op_type                 q_op
);

   logic [PIXEL_W-1:0]   low_ff, low_in;
   logic [PIXEL_W-1:0]   high_ff, high_in;
   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     in_row_ff, in_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic                 extra_ff, extra_in;

   logic [31:0]      w_eff;
   logic [31:0]      h_eff;
   logic [COL_W-1:0] wm1;
   logic [ROW_W-1:0] hm1;
   logic [ROW_W-1:0] h_count;
   class_type        cls;
   logic             col_wrap;
   logic [COL_W-1:0] col_next;
   logic             out_col_wrap;
   logic             out_last;
   logic             complete;
   logic             started;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = 32'd1;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = 32'(MAX_WIDTH);
      end else begin
         w_eff = 32'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = 32'd1;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = 32'(MAX_HEIGHT);
      end else begin
         h_eff = 32'(height_ff);
      end
   end

   assign wm1     = COL_W'(w_eff - 32'd1);
   assign hm1     = ROW_W'(h_eff - 32'd1);
   assign h_count = ROW_W'(h_eff);

   always_comb begin
      priority if (req_tdata <= low_ff) begin
         cls = CLS_NONE;
      end else if (req_tdata >= high_ff) begin
         cls = CLS_STRONG;
      end else begin
         cls = CLS_WEAK;
      end
   end

   assign col_wrap     = (col_ff == wm1);
   assign col_next     = col_wrap ? '0 : col_ff + COL_W'(1);
   assign out_col_wrap = (out_col_ff == wm1);
   assign out_last     = out_col_wrap && (out_row_ff == hm1);
   assign complete     = (in_row_ff == h_count);
   assign started      = (in_row_ff > ROW_W'(1)) ||
                         ((in_row_ff == ROW_W'(1)) && (col_ff != '0));

   assign req_tready = !q_full && !extra_ff && !csr_valid;
   assign csr_ready  = 1'b1;

   always_comb begin
      low_in     = low_ff;
      high_in    = high_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      extra_in   = extra_ff;
      q_push     = 1'b0;

      q_op.emit       = 1'b0;
      q_op.last       = 1'b0;
      q_op.cls        = cls;
      q_op.col        = col_ff;
      q_op.mask_top   = (out_row_ff == '0);
      q_op.mask_bot   = (out_row_ff == hm1);
      q_op.mask_left  = (out_col_ff == '0);
      q_op.mask_right = out_col_wrap;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_LOW:    low_in    = csr_data[PIXEL_W-1:0];
            REG_HIGH:   high_in   = csr_data[PIXEL_W-1:0];
            REG_WIDTH:  width_in  = csr_data;
            REG_HEIGHT: height_in = csr_data;
            default:    low_in    = low_ff;
         endcase
         if ((csr_index_type'(csr_index) == REG_WIDTH) ||
             (csr_index_type'(csr_index) == REG_HEIGHT)) begin
            col_in     = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            extra_in   = 1'b0;
         end
      end else if (extra_ff) begin
         // prime the window once more for a single-line frame
         if (!q_full) begin
            q_push   = 1'b1;
            col_in   = col_next;
            extra_in = 1'b0;
         end
      end else if (req_tvalid && req_tready) begin
         if (!complete) begin
            if (req_tuser == MODE_PIXEL) begin
               q_push    = 1'b1;
               q_op.emit = started;
               col_in    = col_next;
               if (col_wrap) begin
                  in_row_in = in_row_ff + ROW_W'(1);
               end
               if (started) begin
                  out_col_in = out_col_wrap ? '0 : out_col_ff + COL_W'(1);
                  if (out_col_wrap) begin
                     out_row_in = out_row_ff + ROW_W'(1);
                  end
               end
               if (col_wrap && (in_row_ff == hm1) && (hm1 == '0)) begin
                  extra_in = 1'b1;
               end
            end
         end else begin
            q_push     = 1'b1;
            q_op.emit  = 1'b1;
            q_op.last  = out_last;
            col_in     = col_next;
            out_col_in = out_col_wrap ? '0 : out_col_ff + COL_W'(1);
            if (out_col_wrap) begin
               out_row_in = out_row_ff + ROW_W'(1);
            end
            if (out_last) begin
               col_in     = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff     <= LOW_RESET;
         high_ff    <= HIGH_RESET;
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         col_ff     <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         extra_ff   <= 1'b0;
      end else begin
         low_ff     <= low_in;
         high_ff    <= high_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_ff     <= col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         extra_ff   <= extra_in;
      end
   end

   `HET_CHECK(a_col_in_line, col_ff <= wm1, "line store column beyond image width")
   `HET_CHECK(a_out_col_in_line, out_col_ff <= wm1, "result column beyond image width")
   `HET_CHECK(a_extra_single_line, !extra_ff || ((hm1 == '0) && (in_row_ff == ROW_W'(1))),
      "window priming pending outside a finished single-line frame")

endmodule

// ===== design/het_queue.sv =====
module het_queue import het_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   valid,
   output op_type head
);

   op_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/het_back.sv =====
`include "hysteresis_edge_threshold_top_macros.svh"

module het_back import het_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  op_type            q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [EDGE_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   logic          s1_valid_ff, s1_valid_in;
   op_type        s1_op_ff;
   logic          fwd_ff;
   line_word_type fwd_word_ff;
   column_type    win_a_ff;
   column_type    win_b_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [EDGE_W-1:0] rsp_data_ff;
   logic          rsp_last_ff;

   logic          s1_fire;
   line_word_type ram_rdata;
   line_word_type rd_word;
   line_word_type wr_word;
   column_type    new_col;
   logic          near_strong;
   logic          edge_on;

   assign s1_fire = s1_valid_ff && (!s1_op_ff.emit || !rsp_valid_ff || rsp_tready);
   assign q_pop   = q_valid && (!s1_valid_ff || s1_fire);

   assign rd_word       = fwd_ff ? fwd_word_ff : ram_rdata;
   assign wr_word.older = rd_word.newer;
   assign wr_word.newer = s1_op_ff.cls;

   het_ram #(
      .WIDTH (LINE_WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock (clock),
      .we    (s1_fire),
      .waddr (s1_op_ff.col),
      .wdata (wr_word),
      .re    (q_pop),
      .raddr (q_head.col),
      .rdata (ram_rdata)
   );

   assign new_col.top = rd_word.older;
   assign new_col.mid = rd_word.newer;
   assign new_col.bot = s1_op_ff.cls;

   always_comb begin
      near_strong =
         (!s1_op_ff.mask_left &&
            ((!s1_op_ff.mask_top && (win_a_ff.top == CLS_STRONG)) ||
             (win_a_ff.mid == CLS_STRONG) ||
             (!s1_op_ff.mask_bot && (win_a_ff.bot == CLS_STRONG)))) ||
         (!s1_op_ff.mask_top && (win_b_ff.top == CLS_STRONG)) ||
         (!s1_op_ff.mask_bot && (win_b_ff.bot == CLS_STRONG)) ||
         (!s1_op_ff.mask_right &&
            ((!s1_op_ff.mask_top && (new_col.top == CLS_STRONG)) ||
             (new_col.mid == CLS_STRONG) ||
             (!s1_op_ff.mask_bot && (new_col.bot == CLS_STRONG))));
      edge_on = (win_b_ff.mid == CLS_STRONG) ||
                ((win_b_ff.mid == CLS_WEAK) && near_strong);
   end

   always_comb begin
      priority if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      priority if (s1_fire && s1_op_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_op_ff    <= q_head;
         fwd_ff      <= s1_fire && (s1_op_ff.col == q_head.col);
         fwd_word_ff <= wr_word;
      end
      if (s1_fire) begin
         win_a_ff <= win_b_ff;
         win_b_ff <= new_col;
      end
      if (s1_fire && s1_op_ff.emit) begin
         rsp_data_ff <= edge_on ? EDGE_ON : EDGE_OFF;
         rsp_last_ff <= s1_op_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HET_CHECK_NEXT(a_pop_fills_stage, q_pop, s1_valid_ff, "popped op did not reach the stage")
   `HET_CHECK_NEXT(a_stall_holds_stage,
      s1_valid_ff && s1_op_ff.emit && rsp_valid_ff && !rsp_tready,
      s1_valid_ff && $stable(s1_op_ff), "stalled op changed")
   `HET_CHECK_NEXT(a_emit_loads_output, s1_fire && s1_op_ff.emit,
      rsp_valid_ff && (rsp_last_ff == $past(s1_op_ff.last)), "result not loaded")

endmodule

// ===== design/hysteresis_edge_threshold_top.sv =====
// channel  dir  handshake                payload
// req      in   req_tvalid / req_tready  tdata[7:0] pixel, tuser mode
// rsp      out  rsp_tvalid / rsp_tready  tdata[7:0] edge_value, tlast frame_last
// csr      in   csr_valid / csr_ready    csr_index[1:0], csr_data[10:0]
//
// One req beat per clock while rsp keeps up and no csr beat or window priming
// holds the front. After the beat that releases it, a result passes the queue
// slot, line RAM read stage and result register. A single-line frame holds
// req_tready low after its last pixel to prime the 3x3 window from the line RAM.
// Reset is synchronous: control registers take defaults, data and line RAM do not.
// A stalled rsp holds the back stage; the four-entry op queue then fills and
// drops req_tready. csr_ready stays high; a csr beat takes the front for its cycle.
module hysteresis_edge_threshold_top import het_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,  // [7:0] pixel
   input  logic                   req_tuser,  // [0] mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [EDGE_W-1:0]      rsp_tdata,  // [7:0] edge_value
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_DIM_W-1:0]   csr_data
);

   logic   q_full;
   logic   q_push;
   op_type q_push_op;
   logic   q_pop;
   logic   q_valid;
   op_type q_head;

   het_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_op       (q_push_op)
   );

   het_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .full    (q_full),
      .pop     (q_pop),
      .valid   (q_valid),
      .head    (q_head)
   );

   het_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
